// ----- hdl/mbrtu_pkg.sv -----
package mbrtu_pkg;

  localparam int MaxRegsDef = 32;

  localparam logic [1:0] REQ_START = 2'd0;
  localparam logic [1:0] REQ_BYTE  = 2'd1;
  localparam logic [1:0] REQ_TICK  = 2'd2;
  localparam logic [1:0] REQ_BAD   = 2'd3;

  localparam logic [1:0] FSEL_RD_HOLD = 2'd0;
  localparam logic [1:0] FSEL_RD_INP  = 2'd1;
  localparam logic [1:0] FSEL_WR_ONE  = 2'd2;
  localparam logic [1:0] FSEL_BAD     = 2'd3;

  localparam logic [7:0] FC_RD_HOLD = 8'h03;
  localparam logic [7:0] FC_RD_INP  = 8'h04;
  localparam logic [7:0] FC_WR_ONE  = 8'h06;

  localparam logic [1:0] KIND_TX   = 2'd0;
  localparam logic [1:0] KIND_WORD = 2'd1;
  localparam logic [1:0] KIND_STAT = 2'd2;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_CRC     = 2'd1;
  localparam logic [1:0] STAT_BYTECNT = 2'd2;
  localparam logic [1:0] STAT_TIMEOUT = 2'd3;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [15:0] TICK_MAX = 16'hFFFF;

  typedef enum logic [8:0] {
    ST_IDLE = 9'b000000001,
    ST_TXB  = 9'b000000010,
    ST_TXF  = 9'b000000100,
    ST_RXF  = 9'b000001000,
    ST_STAT = 9'b000010000,
    ST_RDH  = 9'b000100000,
    ST_RDL  = 9'b001000000,
    ST_RDW  = 9'b010000000,
    ST_WORD = 9'b100000000
  } state_t;

  // one bit of the reflected CRC-16 shift
  function automatic logic [15:0] crc_bit(input logic [15:0] c);
    crc_bit = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
  endfunction

endpackage

// ----- hdl/modbus_rtu_master_transaction_core.sv -----
// Channel  Dir  Handshake          Payload
// in_      in   in_valid/in_stall  req_type function_sel slave_id reg_address
//                                  reg_value reg_count timeout_ticks rx_byte
// out_     out  out_valid/out_stall kind tx_byte reg_word reg_index status last
//
// One bit-serial CRC unit folds one bit per cycle: it folds each of the first
// six frame bytes of a request before the next byte is sent, and each received
// byte covered by the CRC before the next input is taken.
// The final byte of a read then walks the response RAM word by word (RDH, RDL, RDW, WORD).
// rst_n is synchronous; it clears control state only. out_stall holds the
// current transaction in place; no input is taken until the block is idle.
module modbus_rtu_master_transaction_core import mbrtu_pkg::*; #(
  parameter int MAX_REGS = MaxRegsDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_req_type,
  input  logic [1:0]  in_function_sel,
  input  logic [7:0]  in_slave_id,
  input  logic [15:0] in_reg_address,
  input  logic [15:0] in_reg_value,
  input  logic [5:0]  in_reg_count,
  input  logic [15:0] in_timeout_ticks,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_tx_byte,
  output logic [15:0] out_reg_word,
  output logic [4:0]  out_reg_index,
  output logic [1:0]  out_status,
  output logic        out_last
);

  localparam int RespDepth = 2 * MAX_REGS + 8;
  localparam int AW        = $clog2(RespDepth);
  localparam int CNT_W     = $clog2(MAX_REGS + 1);
  localparam int LEN_W     = $clog2(2 * MAX_REGS + 9);

  state_t st_r, st_nxt;
  logic   wait_r, wait_nxt;

  logic [7:0]       slave_r, slave_nxt;
  logic [1:0]       func_r, func_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic [LEN_W-1:0] rcnt_r, rcnt_nxt;
  logic [15:0]      tout_r, tout_nxt;
  logic [15:0]      el_r, el_nxt;
  logic [15:0]      addr_r, addr_nxt;
  logic [15:0]      pay_r, pay_nxt;
  logic [15:0]      crc_r, crc_nxt;   // shared serial fold register
  logic [15:0]      rcrc_r, rcrc_nxt; // running response CRC
  logic [2:0]       bit_r, bit_nxt;
  logic [2:0]       byte_r, byte_nxt;
  logic [7:0]       bcnt_r, bcnt_nxt; // response byte 2
  logic [7:0]       prev_r, prev_nxt; // previous response byte
  logic [7:0]       hi_r, hi_nxt;
  logic [CNT_W-1:0] wi_r, wi_nxt;

  logic [1:0]  kind_r, kind_nxt;
  logic [7:0]  txb_r, txb_nxt;
  logic [15:0] word_r, word_nxt;
  logic [4:0]  ridx_r, ridx_nxt;
  logic [1:0]  stat_r, stat_nxt;
  logic        last_r, last_nxt;

  logic          ram_we;
  logic [AW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;

  logic             in_acc, out_acc;
  logic [6:0]       cnt_in;
  logic [CNT_W-1:0] cnt_sat;
  logic [7:0]       fcode;
  logic [15:0]      crc_step;
  logic [LEN_W:0]   idx_p3;
  logic [15:0]      el_inc;

  assign in_stall  = (st_r != ST_IDLE);
  assign out_valid = (st_r == ST_TXB) || (st_r == ST_STAT) || (st_r == ST_WORD);
  assign in_acc    = in_valid && !in_stall;
  assign out_acc   = out_valid && !out_stall;

  assign out_kind      = kind_r;
  assign out_tx_byte   = txb_r;
  assign out_reg_word  = word_r;
  assign out_reg_index = ridx_r;
  assign out_status    = stat_r;
  assign out_last      = last_r;

  assign cnt_in   = {1'b0, in_reg_count};
  assign cnt_sat  = (cnt_in > 7'(MAX_REGS)) ? CNT_W'(MAX_REGS) : CNT_W'(in_reg_count);
  assign crc_step = crc_bit(crc_r);
  assign idx_p3   = {1'b0, rcnt_r} + (LEN_W+1)'(3);
  assign el_inc   = (el_r < TICK_MAX) ? el_r + 16'd1 : el_r;

  always_comb begin
    unique case (func_r)
      FSEL_RD_HOLD: fcode = FC_RD_HOLD;
      FSEL_RD_INP:  fcode = FC_RD_INP;
      default:      fcode = FC_WR_ONE;
    endcase
  end

  // frame byte for a position of the request
  function automatic logic [7:0] frame_byte(input logic [2:0] p, input logic [7:0] sl,
                                            input logic [7:0] fc, input logic [15:0] ad,
                                            input logic [15:0] pl, input logic [15:0] cr);
    unique case (p)
      3'd0:    frame_byte = sl;
      3'd1:    frame_byte = fc;
      3'd2:    frame_byte = ad[15:8];
      3'd3:    frame_byte = ad[7:0];
      3'd4:    frame_byte = pl[15:8];
      3'd5:    frame_byte = pl[7:0];
      3'd6:    frame_byte = cr[7:0];
      default: frame_byte = cr[15:8];
    endcase
  endfunction

  assign ram_we    = in_acc && wait_r && (in_req_type == REQ_BYTE);
  assign ram_raddr = AW'({wi_r, 1'b0}) + ((st_r == ST_RDL) ? AW'(4) : AW'(3));

  mbrtu_ram #(.Width(8), .Depth(RespDepth)) u_resp (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (AW'(rcnt_r)),
    .wdata   (in_rx_byte),
    .raddr   (ram_raddr),
    .rdata_r (ram_rdata)
  );

  always_comb begin
    st_nxt   = st_r;
    wait_nxt = wait_r;
    slave_nxt = slave_r;  func_nxt = func_r;  cnt_nxt = cnt_r;  len_nxt = len_r;
    rcnt_nxt = rcnt_r;    tout_nxt = tout_r;  el_nxt = el_r;    addr_nxt = addr_r;
    pay_nxt  = pay_r;     crc_nxt = crc_r;    rcrc_nxt = rcrc_r; bit_nxt = bit_r;
    byte_nxt = byte_r;    bcnt_nxt = bcnt_r;  prev_nxt = prev_r; hi_nxt = hi_r;
    wi_nxt   = wi_r;
    kind_nxt = kind_r;    txb_nxt = txb_r;    word_nxt = word_r; ridx_nxt = ridx_r;
    stat_nxt = stat_r;    last_nxt = last_r;

    unique case (st_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_req_type == REQ_START && in_function_sel != FSEL_BAD) begin
            wait_nxt  = 1'b0;
            slave_nxt = in_slave_id;
            func_nxt  = in_function_sel;
            cnt_nxt   = cnt_sat;
            tout_nxt  = in_timeout_ticks;
            el_nxt    = '0;
            rcnt_nxt  = '0;
            addr_nxt  = in_reg_address;
            if (in_function_sel == FSEL_WR_ONE) begin
              pay_nxt = in_reg_value;
              len_nxt = LEN_W'(8);
            end else begin
              pay_nxt = 16'(cnt_sat);
              len_nxt = LEN_W'(5) + LEN_W'({cnt_sat, 1'b0});
            end
            crc_nxt  = CRC_INIT;
            byte_nxt = '0;
            kind_nxt = KIND_TX;  txb_nxt = in_slave_id;  word_nxt = '0;
            ridx_nxt = '0;       stat_nxt = STAT_OK;     last_nxt = 1'b0;
            st_nxt   = ST_TXB;
          end else if (wait_r && in_req_type == REQ_BYTE) begin
            rcnt_nxt = rcnt_r + LEN_W'(1);
            prev_nxt = in_rx_byte;
            if (rcnt_r == LEN_W'(2)) begin
              bcnt_nxt = in_rx_byte;
            end
            if (rcnt_r + LEN_W'(1) == len_r) begin
              // response complete
              wait_nxt = 1'b0;
              kind_nxt = KIND_STAT; txb_nxt = '0; word_nxt = '0; ridx_nxt = '0;
              last_nxt = 1'b1;
              st_nxt   = ST_STAT;
              if (prev_r != rcrc_r[7:0] || in_rx_byte != rcrc_r[15:8]) begin
                stat_nxt = STAT_CRC;
              end else if (func_r == FSEL_WR_ONE) begin
                stat_nxt = STAT_OK;
              end else if (bcnt_r != 8'({cnt_r, 1'b0})) begin
                stat_nxt = STAT_BYTECNT;
              end else if (cnt_r == '0) begin
                stat_nxt = STAT_OK;
              end else begin
                wi_nxt = '0;
                st_nxt = ST_RDH;
              end
            end else if (rcnt_r != '0 && idx_p3 <= {1'b0, len_r}) begin
              crc_nxt = rcrc_r ^ {8'h00, in_rx_byte};
              bit_nxt = '0;
              st_nxt  = ST_RXF;
            end
          end else if (wait_r && in_req_type == REQ_TICK) begin
            el_nxt = el_inc;
            if (el_inc >= tout_r) begin
              wait_nxt = 1'b0;
              kind_nxt = KIND_STAT; txb_nxt = '0; word_nxt = '0; ridx_nxt = '0;
              stat_nxt = STAT_TIMEOUT; last_nxt = 1'b1;
              st_nxt   = ST_STAT;
            end
          end
        end
      end
      ST_TXB: begin
        if (out_acc) begin
          if (byte_r < 3'd6) begin
            crc_nxt = crc_r ^ {8'h00, txb_r};
            bit_nxt = '0;
            st_nxt  = ST_TXF;
          end else if (byte_r == 3'd6) begin
            byte_nxt = 3'd7;
            txb_nxt  = crc_r[15:8];
          end else if (tout_r == '0) begin
            kind_nxt = KIND_STAT; txb_nxt = '0;
            stat_nxt = STAT_TIMEOUT; last_nxt = 1'b1;
            st_nxt   = ST_STAT;
          end else begin
            wait_nxt = 1'b1;
            st_nxt   = ST_IDLE;
          end
        end
      end
      ST_TXF: begin
        crc_nxt = crc_step;
        bit_nxt = bit_r + 3'd1;
        if (bit_r == 3'd7) begin
          // fold of the slave byte alone seeds the response CRC
          if (byte_r == 3'd0) begin
            rcrc_nxt = crc_step;
          end
          byte_nxt = byte_r + 3'd1;
          txb_nxt  = frame_byte(byte_r + 3'd1, slave_r, fcode, addr_r, pay_r, crc_step);
          st_nxt   = ST_TXB;
        end
      end
      ST_RXF: begin
        crc_nxt = crc_step;
        bit_nxt = bit_r + 3'd1;
        if (bit_r == 3'd7) begin
          rcrc_nxt = crc_step;
          st_nxt   = ST_IDLE;
        end
      end
      ST_STAT: begin
        if (out_acc) begin
          st_nxt = ST_IDLE;
        end
      end
      ST_RDH: st_nxt = ST_RDL;
      ST_RDL: begin
        hi_nxt = ram_rdata;
        st_nxt = ST_RDW;
      end
      ST_RDW: begin
        kind_nxt = KIND_WORD;
        stat_nxt = STAT_OK;
        word_nxt = {hi_r, ram_rdata};
        ridx_nxt = 5'(wi_r);
        last_nxt = (wi_r + CNT_W'(1) == cnt_r);
        st_nxt   = ST_WORD;
      end
      ST_WORD: begin
        if (out_acc) begin
          if (last_r) begin
            st_nxt = ST_IDLE;
          end else begin
            wi_nxt = wi_r + CNT_W'(1);
            st_nxt = ST_RDH;
          end
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= ST_IDLE;
      wait_r <= 1'b0;
      rcrc_r <= CRC_INIT;
      el_r   <= '0;
      rcnt_r <= '0;
      len_r  <= '0;
      cnt_r  <= '0;
      func_r <= '0;
      slave_r <= '0;
      tout_r <= '0;
    end else begin
      st_r   <= st_nxt;
      wait_r <= wait_nxt;
      rcrc_r <= rcrc_nxt;
      el_r   <= el_nxt;
      rcnt_r <= rcnt_nxt;
      len_r  <= len_nxt;
      cnt_r  <= cnt_nxt;
      func_r <= func_nxt;
      slave_r <= slave_nxt;
      tout_r <= tout_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r <= addr_nxt;
    pay_r  <= pay_nxt;
    crc_r  <= crc_nxt;
    bit_r  <= bit_nxt;
    byte_r <= byte_nxt;
    bcnt_r <= bcnt_nxt;
    prev_r <= prev_nxt;
    hi_r   <= hi_nxt;
    wi_r   <= wi_nxt;
    kind_r <= kind_nxt;
    txb_r  <= txb_nxt;
    word_r <= word_nxt;
    ridx_r <= ridx_nxt;
    stat_r <= stat_nxt;
    last_r <= last_nxt;
  end

endmodule

// ----- hdl/mbrtu_ram.sv -----
module mbrtu_ram import mbrtu_pkg::*; #(
  parameter int Width = 8,
  parameter int Depth = 72
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata_r
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule

// ----- test/modbus_rtu_master_transaction_core_tb.sv -----
`timescale 1ns / 100ps

module modbus_rtu_master_transaction_core_tb;
  import mbrtu_pkg::*;

  localparam int MAX_REGS = 32;
  localparam int WDOG_LIMIT = 20000;

  // One input transaction as driven onto the in_ channel.
  typedef struct packed {
    logic [1:0]  req_type;
    logic [1:0]  function_sel;
    logic [7:0]  slave_id;
    logic [15:0] reg_address;
    logic [15:0] reg_value;
    logic [5:0]  reg_count;
    logic [15:0] timeout_ticks;
    logic [7:0]  rx_byte;
  } req_t;

  // One result transaction from the out_ channel.
  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  tx_byte;
    logic [15:0] reg_word;
    logic [4:0]  reg_index;
    logic [1:0]  status;
    logic        last;
  } res_t;

  // Directed table row; has_exp marks rows whose first result is typed in.
  typedef struct {
    req_t req;
    bit   has_exp;
    res_t exp;
  } row_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_req_type;
  logic [1:0]  in_function_sel;
  logic [7:0]  in_slave_id;
  logic [15:0] in_reg_address;
  logic [15:0] in_reg_value;
  logic [5:0]  in_reg_count;
  logic [15:0] in_timeout_ticks;
  logic [7:0]  in_rx_byte;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  out_kind;
  logic [7:0]  out_tx_byte;
  logic [15:0] out_reg_word;
  logic [4:0]  out_reg_index;
  logic [1:0]  out_status;
  logic        out_last;

  modbus_rtu_master_transaction_core u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_req_type      (in_req_type),
    .in_function_sel  (in_function_sel),
    .in_slave_id      (in_slave_id),
    .in_reg_address   (in_reg_address),
    .in_reg_value     (in_reg_value),
    .in_reg_count     (in_reg_count),
    .in_timeout_ticks (in_timeout_ticks),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_kind         (out_kind),
    .out_tx_byte      (out_tx_byte),
    .out_reg_word     (out_reg_word),
    .out_reg_index    (out_reg_index),
    .out_status       (out_status),
    .out_last         (out_last)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // ---------------------------------------------------------------------
  // Master engine mirror: the state the block should hold.
  // ---------------------------------------------------------------------
  logic        m_waiting;
  logic [7:0]  m_slave;
  logic [1:0]  m_func;
  logic [5:0]  m_count;
  logic [6:0]  m_exp_len;
  logic [6:0]  m_rcvd;
  logic [15:0] m_crc;
  logic [15:0] m_ticks;
  logic [15:0] m_timeout;
  logic [7:0]  m_resp [0:2*MAX_REGS+7];

  res_t expected_q[$];  // results still owed by the block

  int  n_errors;
  int  send_idle_pct;
  int  recv_idle_pct;
  bit  recv_hold;       // long receiver hold-off in progress
  int  idle_cycles;     // watchdog: cycles without any transaction

  function automatic logic [15:0] crc16_fold(logic [15:0] c, logic [7:0] b);
    logic [15:0] r;
    r = c ^ {8'h00, b};
    for (int k = 0; k < 8; k++) r = r[0] ? ((r >> 1) ^ 16'hA001) : (r >> 1);
    return r;
  endfunction

  function automatic res_t mk_res(logic [1:0] kind, logic [7:0] tx, logic [15:0] w,
                                  logic [4:0] idx, logic [1:0] st, logic lst);
    res_t r;
    r.kind = kind; r.tx_byte = tx; r.reg_word = w;
    r.reg_index = idx; r.status = st; r.last = lst;
    return r;
  endfunction

  task automatic master_reset();
    m_waiting = 1'b0; m_slave = '0; m_func = '0; m_count = '0;
    m_exp_len = '0; m_rcvd = '0; m_crc = CRC_INIT; m_ticks = '0; m_timeout = '0;
  endtask

  // Response complete: judge CRC, byte count and emit words or a status.
  task automatic master_finish();
    m_waiting = 1'b0;
    if (m_resp[m_exp_len-2] != m_crc[7:0] || m_resp[m_exp_len-1] != m_crc[15:8])
      expected_q.push_back(mk_res(KIND_STAT, 0, 0, 0, STAT_CRC, 1'b1));
    else if (m_func == FSEL_WR_ONE)
      expected_q.push_back(mk_res(KIND_STAT, 0, 0, 0, STAT_OK, 1'b1));
    else if (m_resp[2] != {m_count, 1'b0})
      expected_q.push_back(mk_res(KIND_STAT, 0, 0, 0, STAT_BYTECNT, 1'b1));
    else if (m_count == 0)
      expected_q.push_back(mk_res(KIND_STAT, 0, 0, 0, STAT_OK, 1'b1));
    else
      for (int i = 0; i < m_count; i++)
        expected_q.push_back(mk_res(KIND_WORD, 0, {m_resp[2*i+3], m_resp[2*i+4]},
                                    i[4:0], STAT_OK, (i + 1 == m_count)));
  endtask

  // Advance the mirror by one accepted transaction, queueing its results.
  task automatic master_step(req_t q);
    logic [7:0]  frame [0:7];
    logic [15:0] c;
    logic [15:0] payload;
    logic [5:0]  cnt;
    case (q.req_type)
      REQ_START: begin
        if (q.function_sel <= FSEL_WR_ONE) begin
          cnt = (q.reg_count > MAX_REGS) ? 6'(MAX_REGS) : q.reg_count;
          m_slave = q.slave_id; m_func = q.function_sel; m_count = cnt;
          m_timeout = q.timeout_ticks; m_ticks = '0; m_rcvd = '0;
          if (q.function_sel == FSEL_WR_ONE) begin
            frame[1] = FC_WR_ONE; payload = q.reg_value; m_exp_len = 7'd8;
          end else begin
            frame[1] = (q.function_sel == FSEL_RD_HOLD) ? FC_RD_HOLD : FC_RD_INP;
            payload = {10'd0, cnt}; m_exp_len = 7'(5 + 2 * cnt);
          end
          frame[0] = q.slave_id;
          frame[2] = q.reg_address[15:8]; frame[3] = q.reg_address[7:0];
          frame[4] = payload[15:8]; frame[5] = payload[7:0];
          c = CRC_INIT;
          for (int i = 0; i < 6; i++) c = crc16_fold(c, frame[i]);
          frame[6] = c[7:0]; frame[7] = c[15:8];
          for (int i = 0; i < 8; i++)
            expected_q.push_back(mk_res(KIND_TX, frame[i], 0, 0, STAT_OK, 1'b0));
          // response CRC seeded with the requested slave id
          m_crc = crc16_fold(CRC_INIT, q.slave_id);
          if (q.timeout_ticks == 0) begin
            expected_q.push_back(mk_res(KIND_STAT, 0, 0, 0, STAT_TIMEOUT, 1'b1));
            m_waiting = 1'b0;
          end else begin
            m_waiting = 1'b1;
          end
        end
      end
      REQ_BYTE: begin
        if (m_waiting && m_rcvd < m_exp_len) begin
          m_resp[m_rcvd] = q.rx_byte;
          if (m_rcvd >= 1 && m_rcvd + 3 <= m_exp_len) m_crc = crc16_fold(m_crc, q.rx_byte);
          m_rcvd = m_rcvd + 1;
          if (m_rcvd == m_exp_len) master_finish();
        end
      end
      REQ_TICK: begin
        if (m_waiting) begin
          if (m_ticks != TICK_MAX) m_ticks = m_ticks + 1;
          if (m_ticks >= m_timeout) begin
            m_waiting = 1'b0;
            expected_q.push_back(mk_res(KIND_STAT, 0, 0, 0, STAT_TIMEOUT, 1'b1));
          end
        end
      end
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------------
  // Stimulus builders
  // ---------------------------------------------------------------------
  function automatic req_t rand_req();
    req_t q;
    q = '{req_type: 2'($urandom), function_sel: 2'($urandom), slave_id: 8'($urandom),
          reg_address: 16'($urandom), reg_value: 16'($urandom),
          reg_count: 6'($urandom), timeout_ticks: 16'($urandom),
          rx_byte: 8'($urandom)};
    return q;
  endfunction

  function automatic req_t start_req(logic [1:0] f, logic [7:0] sid, logic [15:0] addr,
                                     logic [15:0] val, logic [5:0] cnt, logic [15:0] tmo);
    req_t q;
    q = rand_req();
    q.req_type = REQ_START; q.function_sel = f; q.slave_id = sid;
    q.reg_address = addr; q.reg_value = val; q.reg_count = cnt; q.timeout_ticks = tmo;
    return q;
  endfunction

  function automatic req_t byte_req(logic [7:0] b);
    req_t q;
    q = rand_req();
    q.req_type = REQ_BYTE; q.rx_byte = b;
    return q;
  endfunction

  function automatic req_t tick_req();
    req_t q;
    q = rand_req();
    q.req_type = REQ_TICK;
    return q;
  endfunction

  // Present one transaction, hold it until accepted, then update the mirror.
  // in_valid stays high after acceptance; the next send or drain drops it.
  task automatic send(req_t q);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_req_type      <= q.req_type;
    in_function_sel  <= q.function_sel;
    in_slave_id      <= q.slave_id;
    in_reg_address   <= q.reg_address;
    in_reg_value     <= q.reg_value;
    in_reg_count     <= q.reg_count;
    in_timeout_ticks <= q.timeout_ticks;
    in_rx_byte       <= q.rx_byte;
    do @(posedge clk); while (in_stall);
    master_step(q);
  endtask

  // Well-formed response for the current request; corrupt picks a flaw.
  task automatic send_response(int corrupt);
    logic [7:0]  b [0:2*MAX_REGS+7];
    logic [15:0] c;
    int          n;
    n = m_exp_len;
    b[0] = m_slave;
    b[1] = (m_func == FSEL_WR_ONE) ? FC_WR_ONE : (m_func == FSEL_RD_HOLD) ? FC_RD_HOLD
                                                                          : FC_RD_INP;
    if (m_func != FSEL_WR_ONE) b[2] = {m_count, 1'b0}; else b[2] = 8'($urandom);
    for (int i = 3; i < n - 2; i++) b[i] = 8'($urandom);
    if (corrupt == 2) b[2] = b[2] ^ 8'(1 << $urandom_range(7));
    c = crc16_fold(CRC_INIT, m_slave);
    for (int i = 1; i < n - 2; i++) c = crc16_fold(c, b[i]);
    b[n-2] = c[7:0]; b[n-1] = c[15:8];
    if (corrupt == 1) b[n - 1 - $urandom_range(1)] ^= 8'(1 << $urandom_range(7));
    for (int i = 0; i < n; i++) begin
      // an occasional tick between bytes; timeouts here are large
      if ($urandom_range(9) == 0) send(tick_req());
      send(byte_req(b[i]));
    end
  endtask

  // Sender goes quiet until every owed result has come back.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_q.size() != 0);
  endtask

  // ---------------------------------------------------------------------
  // Receiver: random stall, plus the long hold-off when requested.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) out_stall <= 1'b0;
    else out_stall <= recv_hold || (recv_idle_pct > 0 && $urandom_range(99) < recv_idle_pct);
  end

  // Scoreboard: compare each result transaction with the oldest expectation.
  always @(posedge clk) begin
    res_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        $error("unexpected result kind=%0d status=%0d", out_kind, out_status);
        n_errors++;
      end else begin
        e = expected_q.pop_front();
        if (out_kind !== e.kind) begin
          $error("kind: expected %0d actual %0d", e.kind, out_kind); n_errors++;
        end
        if (out_tx_byte !== e.tx_byte) begin
          $error("tx_byte: expected %h actual %h", e.tx_byte, out_tx_byte); n_errors++;
        end
        if (out_reg_word !== e.reg_word) begin
          $error("reg_word: expected %h actual %h", e.reg_word, out_reg_word); n_errors++;
        end
        if (out_reg_index !== e.reg_index) begin
          $error("reg_index: expected %0d actual %0d", e.reg_index, out_reg_index);
          n_errors++;
        end
        if (out_status !== e.status) begin
          $error("status: expected %0d actual %0d", e.status, out_status); n_errors++;
        end
        if (out_last !== e.last) begin
          $error("last: expected %0d actual %0d", e.last, out_last); n_errors++;
        end
      end
    end
  end

  // Watchdog: any cycle with no transaction on either side counts.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG_LIMIT) begin
      $display("modbus_rtu_master_transaction_core_tb: FAIL");
      $finish;
    end
  end

  // Long receiver hold-off, counted here while the sender keeps going.
  task automatic hold_receiver(int cycles);
    recv_hold <= 1'b1;
    repeat (cycles) @(posedge clk);
    recv_hold <= 1'b0;
  endtask

  // ---------------------------------------------------------------------
  // Directed table
  // ---------------------------------------------------------------------
  row_t dir_rows[$];

  task automatic add_row(req_t q, bit has_exp, res_t e);
    row_t r;
    r.req = q; r.has_exp = has_exp; r.exp = e;
    dir_rows.push_back(r);
  endtask

  task automatic build_table();
    res_t none;
    none = '0;
    // byte and tick while idle: ignored
    add_row(byte_req(8'hFF), 0, none);
    add_row(tick_req(), 0, none);
    // unknown req_type and unknown function: ignored
    begin
      req_t q;
      q = rand_req(); q.req_type = REQ_BAD; add_row(q, 0, none);
      q = start_req(FSEL_BAD, 8'h11, 0, 0, 1, 5); add_row(q, 0, none);
    end
    // zero timeout, extremes of every field; first tx byte is the slave id
    add_row(start_req(FSEL_RD_HOLD, 8'hFF, 16'hFFFF, 16'hFFFF, 6'h3F, 16'h0000), 1,
            mk_res(KIND_TX, 8'hFF, 0, 0, STAT_OK, 1'b0));
    add_row(start_req(FSEL_WR_ONE, 8'h00, 16'h0000, 16'h0000, 6'h00, 16'h0000), 1,
            mk_res(KIND_TX, 8'h00, 0, 0, STAT_OK, 1'b0));
    // timeout after two ticks
    add_row(start_req(FSEL_RD_INP, 8'h5A, 16'h1234, 16'h0, 6'd2, 16'd2), 1,
            mk_res(KIND_TX, 8'h5A, 0, 0, STAT_OK, 1'b0));
    add_row(tick_req(), 0, none);
    add_row(tick_req(), 1, mk_res(KIND_STAT, 0, 0, 0, STAT_TIMEOUT, 1'b1));
    // start while waiting drops the pending run
    add_row(start_req(FSEL_WR_ONE, 8'h01, 16'h0001, 16'hA5A5, 6'd0, 16'hFFFF), 0, none);
    add_row(start_req(FSEL_RD_HOLD, 8'h02, 16'h8000, 16'h0, 6'd0, 16'hFFFF), 0, none);
    // count zero read: bytes slave, fc, 0x00, crc lo, crc hi
    add_row(byte_req(8'h02), 0, none);
    add_row(byte_req(FC_RD_HOLD), 0, none);
    add_row(byte_req(8'h00), 0, none);
    // CRC over fc and 0x00 seeded with slave id; wrong CRC here on purpose
    add_row(byte_req(8'h00), 0, none);
    add_row(byte_req(8'h00), 0, none);
  endtask

  // Read/write run with random content; mostly well formed.
  task automatic random_run();
    int kind_sel;
    logic [5:0] cnt;
    cnt = ($urandom_range(9) == 0) ? 6'($urandom_range(33, 63)) : 6'($urandom_range(0, 4));
    send(start_req(2'($urandom_range(2)), 8'($urandom), 16'($urandom), 16'($urandom),
                   cnt, 16'($urandom_range(1000, 65535))));
    kind_sel = $urandom_range(99);
    if (kind_sel < 65) send_response(0);
    else if (kind_sel < 78) send_response(1);
    else if (kind_sel < 88 && m_func != FSEL_WR_ONE) send_response(2);
    else begin
      // noise: random items, possibly a timeout or restart
      repeat ($urandom_range(1, 6)) send(rand_req());
      if ($urandom_range(1) == 0) begin
        send(start_req(2'($urandom_range(2)), 8'($urandom), 16'($urandom),
                       16'($urandom), 6'($urandom_range(0, 3)), 16'($urandom_range(1, 4))));
        repeat ($urandom_range(0, 5)) send(tick_req());
      end
    end
  endtask

  initial begin
    n_errors      = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    recv_hold     = 1'b0;
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_req_type      = REQ_TICK;
    in_function_sel  = FSEL_RD_HOLD;
    in_slave_id      = '0;
    in_reg_address   = '0;
    in_reg_value     = '0;
    in_reg_count     = '0;
    in_timeout_ticks = '0;
    in_rx_byte       = '0;
    master_reset();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: typed-in expectations checked against the mirror's.
    build_table();
    foreach (dir_rows[i]) begin
      int before_n;
      // empty queue so the first new result sits at a known index
      if (dir_rows[i].has_exp) drain();
      before_n = expected_q.size();
      send(dir_rows[i].req);
      if (dir_rows[i].has_exp) begin
        if (expected_q.size() <= before_n || expected_q[before_n] != dir_rows[i].exp) begin
          $error("directed row %0d: first result differs from table", i);
          n_errors++;
        end
      end
    end
    drain();

    // Random part, three idling phases.
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 35 : (ph == 1) ? 62 : 0;
      recv_idle_pct = (ph == 0) ? 62 : (ph == 1) ? 35 : 0;
      for (int r = 0; r < 4; r++) begin
        if (ph == 2 && r == 1) begin
          // receiver holds off long while requests keep coming
          fork
            hold_receiver(400);
            begin random_run(); random_run(); drain(); end
          join
        end
        random_run();
        if (r == 2) drain();  // sender pauses until everything is back
      end
    end
    drain();
    repeat (200) @(posedge clk);
    if (n_errors == 0 && expected_q.size() == 0) begin
      $display("modbus_rtu_master_transaction_core_tb: PASS");
    end else begin
      foreach (expected_q[i]) $error("missing result kind=%0d", expected_q[i].kind);
      $display("modbus_rtu_master_transaction_core_tb: FAIL");
    end
    $finish;
  end

endmodule
